// ----- src/rcta_pkg.sv -----
// types, constants and helper functions for the radix-to-ascii converter
// used by radix_convert_to_ascii; no dependencies
package rcta_pkg;

	localparam int BASE_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_COMMA  = 7'd44;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A      = 7'd65;
	localparam logic [BASE_W-1:0] DIGIT_TEN   = 6'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_INT,
		ST_COMMA,
		ST_MUL,
		ST_FRAC
	} state_t;

	// digit value to ascii code
	function automatic logic [CHAR_W-1:0] ascii_of(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] code;
		if (d < DIGIT_TEN) begin
			code = CHAR_ZERO + CHAR_W'(d);
		end else begin
			code = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return code;
	endfunction

	// register value clamped into the supported radix range
	function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

endpackage

// ----- src/radix_convert_to_ascii.sv -----
// radix converter: non-negative fixed-point number to ascii text, one character per request
// depends on rcta_pkg
//
// usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the radix, 2..36, reset value 10;
//   values below 2 act as 2, above 36 act as 36. cfg_ready is always high.
//   s_axis carries one number: integer part in the low INT_BITS of tdata, Q0.FRAC_BITS
//   fraction above it. m_axis returns ascii characters: integer digits most significant
//   first, a comma, then 1..MAX_FRAC_DIGITS fraction digits; tlast marks the final one.
// operation:
//   each integer digit comes from a bit-serial restoring divider; each fraction digit
//   comes from a bit-serial shift-add multiply and is then emitted; the integer digits
//   and the comma are emitted one at a time.
//   one number is converted at a time; s_axis_tready is high only while idle.
// reset: arst_n clears the control state and sets the radix to 10.
// stall: a low m_axis_tready holds the output register and holds the converter in its emitting
//   states until the character is taken; the divide and multiply steps run on.
module radix_convert_to_ascii #(
	parameter int INT_BITS        = 31,
	parameter int FRAC_BITS       = 32,
	parameter int MAX_FRAC_DIGITS = 10
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [rcta_pkg::BASE_W-1:0]                    cfg_data,      // target_base
	input  logic                                           s_axis_tvalid,
	output logic                                           s_axis_tready,
	input  logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0]        s_axis_tdata,  // int_part, frac_part
	output logic                                           m_axis_tvalid,
	input  logic                                           m_axis_tready,
	output logic [7:0]                                     m_axis_tdata,  // char_code
	output logic                                           m_axis_tlast
);
	import rcta_pkg::*;

	localparam int CNT_W  = $clog2(INT_BITS);
	localparam int DEP_W  = $clog2(INT_BITS + 1);
	localparam int FD_W   = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int ACC_W  = FRAC_BITS + BASE_W;
	localparam int THR_W  = FRAC_BITS + 28;
	localparam logic [THR_W-1:0] FRAC_ONE = THR_W'(1) << FRAC_BITS;
	localparam logic [THR_W-1:0] THR_FULL = FRAC_ONE / THR_W'(100000000);
	localparam logic [FRAC_BITS-1:0] THR = THR_FULL[FRAC_BITS-1:0];

	state_t state_q, state_d;

	logic [BASE_W-1:0]    base_cfg_q;
	logic [BASE_W-1:0]    base_q;
	logic [BASE_W-1:0]    bsh_q;
	logic [INT_BITS-1:0]  n_q;
	logic [BASE_W-1:0]    r_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BASE_W-1:0]    stk_q [INT_BITS];
	logic [DEP_W-1:0]     dep_q;
	logic [FRAC_BITS-1:0] f_q;
	logic [ACC_W-1:0]     acc_q;
	logic [FD_W-1:0]      fd_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;

	logic                 in_acc;
	logic                 slot_free;
	logic                 emit;
	logic [CHAR_W-1:0]    emit_char;
	logic                 emit_last;

	// divider step
	logic [BASE_W:0]      r_sh;
	logic                 q_bit;
	logic [BASE_W-1:0]    r_new;
	logic [INT_BITS-1:0]  n_new;
	logic                 div_end;
	logic                 mul_end;

	// fraction digit
	logic [FRAC_BITS-1:0] f_new;
	logic [BASE_W-1:0]    f_digit;
	logic                 more;

	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;

	assign r_sh    = {r_q, n_q[INT_BITS-1]};
	assign q_bit   = r_sh >= {1'b0, base_q};
	assign r_new   = q_bit ? BASE_W'(r_sh - {1'b0, base_q}) : r_sh[BASE_W-1:0];
	assign n_new   = {n_q[INT_BITS-2:0], q_bit};
	assign div_end = cnt_q == CNT_W'(INT_BITS - 1);
	assign mul_end = cnt_q == CNT_W'(BASE_W - 1);

	assign f_new   = acc_q[FRAC_BITS-1:0];
	assign f_digit = acc_q[ACC_W-1 -: BASE_W];
	assign more    = (f_new > THR) && (fd_q != FD_W'(MAX_FRAC_DIGITS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_end && n_new == '0) state_d = ST_INT;
			end
			ST_INT: begin
				if (slot_free && dep_q == DEP_W'(1)) state_d = ST_COMMA;
			end
			ST_COMMA: begin
				if (slot_free) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_end) state_d = ST_FRAC;
			end
			ST_FRAC: begin
				if (slot_free) state_d = more ? ST_MUL : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		emit          = 1'b0;
		emit_char     = CHAR_COMMA;
		emit_last     = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_INT: begin
				emit      = slot_free;
				emit_char = ascii_of(stk_q[0]);
			end
			ST_COMMA: emit = slot_free;
			ST_FRAC: begin
				emit      = slot_free;
				emit_char = ascii_of(f_digit);
				emit_last = !more;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_cfg_q  <= BASE_RESET;
			out_valid_q <= 1'b0;
			dep_q       <= '0;
			cnt_q       <= '0;
			fd_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) base_cfg_q <= cfg_data;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					dep_q <= '0;
					fd_q  <= '0;
				end
				ST_DIV: begin
					if (div_end) begin
						cnt_q <= '0;
						dep_q <= dep_q + DEP_W'(1);
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_INT: begin
					if (slot_free) dep_q <= dep_q - DEP_W'(1);
				end
				ST_COMMA: cnt_q <= '0;
				ST_MUL: begin
					cnt_q <= mul_end ? '0 : cnt_q + CNT_W'(1);
				end
				ST_FRAC: begin
					if (slot_free) fd_q <= fd_q + FD_W'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					n_q    <= s_axis_tdata[INT_BITS-1:0];
					f_q    <= s_axis_tdata[INT_BITS +: FRAC_BITS];
					base_q <= eff_base(base_cfg_q);
					r_q    <= '0;
				end
			end
			ST_DIV: begin
				n_q <= n_new;
				if (div_end) begin
					r_q      <= '0;
					stk_q[0] <= r_new;
					for (int i = 1; i < INT_BITS; i++) stk_q[i] <= stk_q[i-1];
				end else begin
					r_q <= r_new;
				end
			end
			ST_INT: begin
				if (slot_free) begin
					for (int i = 0; i < INT_BITS - 1; i++) stk_q[i] <= stk_q[i+1];
				end
			end
			ST_COMMA: begin
				acc_q <= '0;
				bsh_q <= base_q;
			end
			ST_MUL: begin
				acc_q <= {acc_q[ACC_W-2:0], 1'b0} + (bsh_q[BASE_W-1] ? ACC_W'(f_q) : '0);
				bsh_q <= {bsh_q[BASE_W-2:0], 1'b0};
			end
			ST_FRAC: begin
				if (slot_free) begin
					f_q   <= f_new;
					acc_q <= '0;
					bsh_q <= base_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_char_q};
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input taken while a conversion runs");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dep_q <= DEP_W'(INT_BITS))
		else $error("digit stack overflow");

	a_stack_empty_in_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_FRAC || state_q == ST_COMMA) |-> dep_q == '0)
		else $error("integer digits left over in fraction phase");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (base_q >= BASE_MIN && base_q <= BASE_MAX))
		else $error("latched radix out of range");

	a_frac_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> fd_q < FD_W'(MAX_FRAC_DIGITS))
		else $error("too many fraction digits");
`endif

endmodule

// ----- verif/tb_radix_convert_to_ascii.sv -----
// self-checking testbench for radix_convert_to_ascii: numbers in, ascii characters out,
// every character compared with typed text or a predictor; random radix settings and handshake stalls
// depends on rcta_pkg and radix_convert_to_ascii
module tb_radix_convert_to_ascii;
	import rcta_pkg::*;

	localparam int                IDLE_LIMIT      = 20000;
	localparam int                DRAIN_CYCLES    = 500;
	localparam int                FRAC_DIGITS_MAX = 10;
	localparam longint unsigned   FRAC_STOP       = 64'h1_0000_0000 / 100000000;
	localparam int                PHASES          = 9;
	localparam int                PHASE_ITEMS     = 50;
	localparam int                N_ROWS          = 21;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} glyph_t;

	typedef struct {
		logic [BASE_W-1:0] radix_reg;
		logic [30:0]       whole;
		logic [31:0]       frac;
		string             text;
	} number_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [BASE_W-1:0] cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata;   // int_part [30:0], frac_part [62:31], zero [63]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;   // char_code [6:0], zero [7]
	logic              m_axis_tlast;

	glyph_t            pending_glyphs[$];
	glyph_t            want;
	logic [BASE_W-1:0] radix_copy;
	bit                calm = 1'b0;
	int                stall_left = 0;
	int                quiet_cycles = 0;
	int                n_errors = 0;
	int                n_numbers = 0;
	int                n_chars = 0;
	int                n_settings = 0;

	number_row_t rows [0:N_ROWS-1] = '{
		'{6'd10, 31'd0,          32'd0,          "0,0"},
		'{6'd10, 31'h7FFF_FFFF,  32'd0,          "2147483647,0"},
		'{6'd10, 31'd0,          32'h8000_0000,  "0,5"},
		'{6'd10, 31'd1,          32'hFFFF_FFFF,  ""},
		'{6'd10, 31'd0,          32'd1,          ""},
		'{6'd10, 31'd0,          32'd43,         ""},
		'{6'd2,  31'd0,          32'd0,          "0,0"},
		'{6'd2,  31'h7FFF_FFFF,  32'hFFFF_FFFF,
			"1111111111111111111111111111111,1111111111"},
		'{6'd2,  31'd1,          32'h8000_0000,  "1,1"},
		'{6'd16, 31'h7FFF_FFFF,  32'h1234_5678,  "7FFFFFFF,12345678"},
		'{6'd16, 31'd0,          32'h1000_0002,  "0,1"},
		'{6'd16, 31'd0,          32'h1000_0003,  ""},
		'{6'd36, 31'd35,         32'd0,          "Z,0"},
		'{6'd36, 31'h7FFF_FFFF,  32'hFFFF_FFFF,  ""},
		'{6'd0,  31'd5,          32'd0,          "101,0"},
		'{6'd1,  31'd2,          32'hC000_0000,  "10,11"},
		'{6'd37, 31'd36,         32'd0,          "10,0"},
		'{6'd63, 31'd71,         32'd0,          "1Z,0"},
		'{6'd3,  31'd12345,      32'h5555_5555,  ""},
		'{6'd35, 31'h4D2,        32'hABCD_EF01,  ""},
		'{6'd10, 31'h7FFF_FFFF,  32'hFFFF_FFFF,  ""}
	};

	radix_convert_to_ascii i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [CHAR_W-1:0] digit_glyph(input int unsigned d);
		if (d < 10) begin
			return CHAR_ZERO + CHAR_W'(d);
		end
		return CHAR_A + CHAR_W'(d - 10);
	endfunction

	// expected characters of one number under the given radix register value
	function automatic void predict_text(input logic [30:0] whole_in, input logic [31:0] frac_in,
			input logic [BASE_W-1:0] radix_reg);
		int unsigned     radix;
		int unsigned     whole;
		int unsigned     digits[$];
		longint unsigned prod;
		longint unsigned rest;
		int unsigned     nfrac;
		bit              more;
		if (radix_reg < BASE_MIN) begin
			radix = BASE_MIN;
		end else if (radix_reg > BASE_MAX) begin
			radix = BASE_MAX;
		end else begin
			radix = radix_reg;
		end
		whole = whole_in;
		do begin
			digits.push_front(whole % radix);
			whole = whole / radix;
		end while (whole != 0);
		foreach (digits[i]) begin
			pending_glyphs.push_back('{digit_glyph(digits[i]), 1'b0});
		end
		pending_glyphs.push_back('{CHAR_COMMA, 1'b0});
		rest = frac_in;
		nfrac = 0;
		do begin
			prod = rest * radix;
			rest = prod & 64'hFFFF_FFFF;
			nfrac++;
			more = (rest > FRAC_STOP) && (nfrac < FRAC_DIGITS_MAX);
			pending_glyphs.push_back('{digit_glyph(int'(prod >> 32)), !more});
		end while (more);
	endfunction

	// offer one number; on acceptance queue its characters, typed text if given
	task automatic send_number(input logic [30:0] whole, input logic [31:0] frac,
			input string text);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, frac, whole};
		do @(posedge clk); while (!s_axis_tready);
		n_numbers++;
		if (text.len() > 0) begin
			for (int i = 0; i < text.len(); i++) begin
				pending_glyphs.push_back('{CHAR_W'(text[i]), i == text.len() - 1});
			end
		end else begin
			predict_text(whole, frac, radix_copy);
		end
	endtask

	task automatic drain_to_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_radix(input logic [BASE_W-1:0] value);
		drain_to_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		radix_copy = value;
		n_settings++;
	endtask

	function automatic logic [30:0] pick_whole();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(0, 99));
			default: return 31'($urandom >> $urandom_range(1, 31));
		endcase
	endfunction

	function automatic logic [31:0] pick_frac();
		int unsigned k;
		k = $urandom_range(0, 31);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(0, 100));
			3: return ($urandom >> k) << k;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [BASE_W-1:0] pick_radix(input int phase);
		logic [BASE_W-1:0] fixed_radix [0:3] = '{6'd2, 6'd36, 6'd10, 6'd63};
		if (phase < 4) begin
			return fixed_radix[phase];
		end
		if ($urandom_range(0, 7) == 0) begin
			return BASE_W'($urandom_range(0, 63));
		end
		return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
	endfunction

	// output stalls in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= $urandom_range(0, 9);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			n_chars++;
			if (pending_glyphs.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected char, expected none, got %0d last %0d",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = pending_glyphs.pop_front();
				if (m_axis_tdata !== {1'b0, want.code}) begin
					n_errors++;
					$display("%0t: char_code mismatch, expected %0d, got %0d",
						$time, want.code, m_axis_tdata);
				end
				if (m_axis_tlast !== want.last) begin
					n_errors++;
					$display("%0t: last_char mismatch, expected %0d, got %0d",
						$time, want.last, m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		radix_copy    = BASE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed numbers, radix rewritten only where a row changes it
		for (int r = 0; r < N_ROWS; r++) begin
			if (rows[r].radix_reg != radix_copy) begin
				write_radix(rows[r].radix_reg);
			end
			send_number(rows[r].whole, rows[r].frac, rows[r].text);
		end

		// random numbers, one radix setting per phase, no stalls in the last phase
		for (int p = 0; p < PHASES; p++) begin
			write_radix(pick_radix(p));
			if (p == PHASES - 1) begin
				calm = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_number(pick_whole(), pick_frac(), "");
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_glyphs.size() != 0) begin
			n_errors++;
			$display("%0t: %0d expected chars never arrived", $time, pending_glyphs.size());
		end

		$display("run covered %0d numbers under %0d radix writes, %0d characters checked",
			n_numbers, n_settings, n_chars);
		if (n_errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/rcta_pkg.sv
src/radix_convert_to_ascii.sv
verif/tb_radix_convert_to_ascii.sv
